FILE: sv/psd_pkg.sv
// psd_pkg: shared types, constants and control structs for the polygon
// signed distance block. Used by psd_ctrl, psd_dp and the top level.
// No dependencies.
package psd_pkg;

	// Vertex table geometry
	localparam int MAX_VERTICES = 16;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int VCNT_W       = 5;
	localparam logic [VCNT_W-1:0] VCOUNT_RST = VCNT_W'(3);
	localparam logic [VCNT_W-1:0] VCOUNT_MIN = VCNT_W'(3);
	localparam logic [VCNT_W-1:0] VCOUNT_MAX = VCNT_W'(MAX_VERTICES);

	// Item modes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Iteration counts: 16 quotient bits, 20 root bits
	localparam int STEP_W     = 5;
	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(15);
	localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(19);

	typedef struct packed {
		logic              mode;
		logic [3:0]        vertex_index;
		logic signed [15:0] x_coord;
		logic signed [15:0] y_coord;
	} in_t;

	typedef struct packed {
		logic signed [15:0] signed_distance;
		logic              inside_res;
		logic              saturated;
	} out_t;

	// Controller to datapath
	typedef struct packed {
		logic wr;        // write one vertex
		logic query;     // latch query point, rewind edge walk
		logic diff;      // edge and point vectors
		logic t_clr;     // force projection to zero
		logic prod;      // dot and cross products
		logic sum;       // numerator and denominator
		logic dec;       // projection clamp, parity update, divider load
		logic div_step;  // one quotient bit
		logic emul;      // edge times projection
		logic bsub;      // residual vector
		logic sq;        // residual squares
		logic min_ld;    // keep minimum squared distance
		logic min_init;  // first load of the minimum
		logic adv;       // next edge
		logic sqrt_init;
		logic sqrt_step; // one root bit
		logic fin;       // round, sign and saturate
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_div;
		logic last_edge;
	} sts_t;

endpackage

FILE: sv/psd_dp.sv
// psd_dp: datapath of the polygon signed distance block: vertex memory,
// edge arithmetic, shift-subtract divider and bit-serial square root.
// Depends on psd_pkg.
module psd_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  psd_pkg::in_t                         req,
	input  logic                                 cfg_we,
	input  logic [psd_pkg::VCNT_W-1:0]           cfg_wdata,
	input  psd_pkg::cmd_t                        cmd,
	output psd_pkg::sts_t                        sts,
	output psd_pkg::out_t                        rsp
);

	logic [psd_pkg::VCNT_W-1:0] vcount_q;
	logic [psd_pkg::VIDX_W-1:0] nm1, nm1_q, i_q, j_q;

	logic signed [15:0] mem_x [psd_pkg::MAX_VERTICES];
	logic signed [15:0] mem_y [psd_pkg::MAX_VERTICES];
	logic signed [15:0] vxi_q, vyi_q, vxj_q, vyj_q;
	logic signed [15:0] px_q, py_q;

	logic signed [16:0] ex_q, ey_q, wx_q, wy_q;
	logic signed [33:0] wxex_q, wyey_q, exex_q, eyey_q, exwy_q, eywx_q;
	logic signed [34:0] num_q;
	logic        [33:0] den_q;
	logic signed [34:0] den_s;
	logic        [34:0] rem_q, rem2, den_x;
	logic               div_ge;
	logic        [16:0] t_q;
	logic signed [34:0] ptx_q, pty_q;
	logic signed [35:0] rx, ry;
	logic signed [19:0] bxw, byw;
	logic signed [18:0] bx_q, by_q;
	logic        [37:0] sqx_q, sqy_q;
	logic        [38:0] bb, d_q;
	logic               inside_q;
	logic               ba, bbl, bc;

	logic [39:0] sd_q, sr_q, sb_q, trial;
	logic [20:0] rr;
	psd_pkg::out_t rsp_q;
	psd_pkg::out_t fin_v;

	// Vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= psd_pkg::VCOUNT_RST;
		end else if (cfg_we) begin
			vcount_q <= cfg_wdata;
		end
	end

	// Clamp the count in use to [3, MAX_VERTICES]; keep count minus one
	always_comb begin
		if (vcount_q < psd_pkg::VCOUNT_MIN) begin
			nm1 = psd_pkg::VIDX_W'(psd_pkg::VCOUNT_MIN - 1'b1);
		end else if (vcount_q > psd_pkg::VCOUNT_MAX) begin
			nm1 = psd_pkg::VIDX_W'(psd_pkg::VCOUNT_MAX - 1'b1);
		end else begin
			nm1 = psd_pkg::VIDX_W'(vcount_q - 1'b1);
		end
	end

	// Edge walk pointers: i is the current vertex, j the previous one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q   <= '0;
			j_q   <= '0;
			nm1_q <= '0;
		end else if (cmd.query) begin
			i_q   <= '0;
			j_q   <= nm1;
			nm1_q <= nm1;
		end else if (cmd.adv) begin
			j_q <= i_q;
			i_q <= i_q + 1'b1;
		end
	end

	assign sts.last_edge = (i_q == nm1_q);

	// Vertex memory, one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_x[req.vertex_index] <= req.x_coord;
			mem_y[req.vertex_index] <= req.y_coord;
		end
		vxi_q <= mem_x[i_q];
		vyi_q <= mem_y[i_q];
		vxj_q <= mem_x[j_q];
		vyj_q <= mem_y[j_q];
	end

	// Query point
	always_ff @(posedge clk) begin
		if (cmd.query) begin
			px_q <= req.x_coord;
			py_q <= req.y_coord;
		end
	end

	// Edge vector e = vj - vi, point vector w = p - vi
	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			ex_q <= 17'(vxj_q) - 17'(vxi_q);
			ey_q <= 17'(vyj_q) - 17'(vyi_q);
			wx_q <= 17'(px_q) - 17'(vxi_q);
			wy_q <= 17'(py_q) - 17'(vyi_q);
		end
	end

	// Products, each straight into a register
	always_ff @(posedge clk) begin
		if (cmd.prod) begin
			wxex_q <= wx_q * ex_q;
			wyey_q <= wy_q * ey_q;
			exex_q <= ex_q * ex_q;
			eyey_q <= ey_q * ey_q;
			exwy_q <= ex_q * wy_q;
			eywx_q <= ey_q * wx_q;
		end
	end

	// Projection numerator w.e and denominator e.e
	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			num_q <= 35'(wxex_q) + 35'(wyey_q);
			den_q <= 34'(exex_q) + 34'(eyey_q);
		end
	end

	assign den_s = $signed({1'b0, den_q});
	assign sts.need_div = (num_q > 35'sd0) && (den_q != '0) && (num_q < den_s);

	// Divider step: one quotient bit per cycle
	assign den_x  = {1'b0, den_q};
	assign rem2   = {rem_q[33:0], 1'b0};
	assign div_ge = (rem2 >= den_x);

	always_ff @(posedge clk) begin
		if (cmd.dec) begin
			rem_q <= num_q[34:0];
			if (num_q <= 35'sd0 || den_q == '0) begin
				t_q <= '0;
			end else if (num_q >= den_s) begin
				t_q <= 17'h10000;
			end else begin
				t_q <= '0;
			end
		end else if (cmd.t_clr) begin
			t_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? (rem2 - den_x) : rem2;
			t_q   <= {t_q[15:0], div_ge};
		end
	end

	// Crossing parity
	assign ba  = (py_q >= vyi_q);
	assign bbl = (py_q < vyj_q);
	assign bc  = (exwy_q > eywx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
		end else if (cmd.query) begin
			inside_q <= 1'b0;
		end else if (cmd.dec && ba == bbl && bbl == bc) begin
			inside_q <= ~inside_q;
		end
	end

	// e * t
	always_ff @(posedge clk) begin
		if (cmd.emul) begin
			ptx_q <= ex_q * $signed({1'b0, t_q});
			pty_q <= ey_q * $signed({1'b0, t_q});
		end
	end

	// Round e*t (t in Q1.16) to an integer (half up), residual b = w - round(e*t)
	assign rx  = 36'(ptx_q) + 36'sd32768;
	assign ry  = 36'(pty_q) + 36'sd32768;
	assign bxw = 20'(wx_q) - rx[35:16];
	assign byw = 20'(wy_q) - ry[35:16];

	always_ff @(posedge clk) begin
		if (cmd.bsub) begin
			bx_q <= bxw[18:0];
			by_q <= byw[18:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sq) begin
			sqx_q <= 38'(bx_q * bx_q);
			sqy_q <= 38'(by_q * by_q);
		end
	end

	// Running minimum of squared distance
	assign bb = {1'b0, sqx_q} + {1'b0, sqy_q};

	always_ff @(posedge clk) begin
		if (cmd.min_ld && (cmd.min_init || bb < d_q)) begin
			d_q <= bb;
		end
	end

	// Square root, one result bit per cycle; sd ends as d - r*r
	assign trial = sr_q + sb_q;

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			sd_q <= {1'b0, d_q};
			sr_q <= '0;
			sb_q <= 40'h1 << 38;
		end else if (cmd.sqrt_step) begin
			if (sd_q >= trial) begin
				sd_q <= sd_q - trial;
				sr_q <= (sr_q >> 1) + sb_q;
			end else begin
				sr_q <= sr_q >> 1;
			end
			sb_q <= sb_q >> 2;
		end
	end

	// Round to nearest, apply sign, saturate
	assign rr = 21'(sr_q) + 21'(sd_q > sr_q);

	always_comb begin
		fin_v.inside_res = inside_q;
		if (inside_q) begin
			fin_v.saturated       = (rr > 21'd32768);
			fin_v.signed_distance = fin_v.saturated ? 16'sh8000 : 16'(-rr);
		end else begin
			fin_v.saturated       = (rr > 21'd32767);
			fin_v.signed_distance = fin_v.saturated ? 16'sh7fff : 16'(rr);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			rsp_q <= fin_v;
		end
	end

	assign rsp = rsp_q;

	// Clamped projection never exceeds one
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emul |-> (t_q <= 17'h10000))
		else $error("projection above one");

	// Divider remainder stays below the denominator
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.div_step) && !$past(cmd.dec) && !cmd.dec && cmd.div_step |-> (rem_q < den_x))
		else $error("divider remainder out of range");

	// Root trial bit is a single bit on every step
	a_root_bit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sqrt_step |-> $onehot(sb_q))
		else $error("root trial bit lost");

endmodule

FILE: sv/psd_ctrl.sv
// psd_ctrl: sequencer for the polygon signed distance block; walks the
// edges, runs divider and square root, issues vertex writes and the result strobe.
// Depends on psd_pkg.
module psd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          mode,
	input  psd_pkg::sts_t sts,
	output psd_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);

	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_FETCH = 14'b00000000000010,
		ST_DIFF  = 14'b00000000000100,
		ST_PROD  = 14'b00000000001000,
		ST_SUM   = 14'b00000000010000,
		ST_DEC   = 14'b00000000100000,
		ST_DIV   = 14'b00000001000000,
		ST_EMUL  = 14'b00000010000000,
		ST_BSUB  = 14'b00000100000000,
		ST_SQ    = 14'b00001000000000,
		ST_MIN   = 14'b00010000000000,
		ST_SQI   = 14'b00100000000000,
		ST_SQRT  = 14'b01000000000000,
		ST_ROUND = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic [psd_pkg::STEP_W-1:0] cnt_q, cnt_d;
	logic first_q, first_d;
	logic done_q;
	logic accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		first_d = first_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && mode == psd_pkg::MODE_WRITE) begin
					cmd.wr = 1'b1;
				end else if (accept) begin
					cmd.query = 1'b1;
					first_d   = 1'b1;
					state_d   = ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_DIFF;
			ST_DIFF: begin
				cmd.diff = 1'b1;
				// first edge: one extra pass with zero projection seeds the minimum
				if (first_q) begin
					cmd.t_clr = 1'b1;
					state_d   = ST_EMUL;
				end else begin
					state_d = ST_PROD;
				end
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d  = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_DEC;
			end
			ST_DEC: begin
				cmd.dec = 1'b1;
				cnt_d   = '0;
				state_d = sts.need_div ? ST_DIV : ST_EMUL;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == psd_pkg::DIV_LAST) begin
					state_d = ST_EMUL;
				end
			end
			ST_EMUL: begin
				cmd.emul = 1'b1;
				state_d  = ST_BSUB;
			end
			ST_BSUB: begin
				cmd.bsub = 1'b1;
				state_d  = ST_SQ;
			end
			ST_SQ: begin
				cmd.sq  = 1'b1;
				state_d = ST_MIN;
			end
			ST_MIN: begin
				cmd.min_ld   = 1'b1;
				cmd.min_init = first_q;
				if (first_q) begin
					first_d = 1'b0;
					state_d = ST_PROD;
				end else if (sts.last_edge) begin
					state_d = ST_SQI;
				end else begin
					cmd.adv = 1'b1;
					state_d = ST_FETCH;
				end
			end
			ST_SQI: begin
				cmd.sqrt_init = 1'b1;
				cnt_d         = '0;
				state_d       = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == psd_pkg::SQRT_LAST) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.fin = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			first_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			first_q <= first_d;
			done_q  <= (state_q == ST_ROUND);
		end
	end

	assign done = done_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state not one-hot");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(state_q == ST_ROUND))
		else $error("result strobe without a finished query");

endmodule

FILE: sv/polygon_signed_distance.sv
// polygon_signed_distance: top level, controller plus datapath.
// Vertex writes leave busy low. A query holds busy while it walks every
// edge, dividing only where the projection needs it, with an extra pass on
// the first edge, then runs root and rounding; done pulses when busy first
// returns low. Edge cost is set by the 16-step divider, the tail by the
// 20-step root.
// Reset: idle, vertex count 3; vertex table holds nothing until written.
module polygon_signed_distance (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  psd_pkg::in_t               req,
	output logic                       done,
	output psd_pkg::out_t              rsp,
	input  logic                       cfg_we,
	input  logic [psd_pkg::VCNT_W-1:0] cfg_wdata
);

	psd_pkg::cmd_t cmd;
	psd_pkg::sts_t sts;

	psd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (req.mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	psd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

FILE: sim/polygon_signed_distance_chk.sv
// polygon_signed_distance_chk: watches the request and result beats of the
// polygon signed distance block, predicts each query result and compares.
// Depends on psd_pkg.
module polygon_signed_distance_chk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  psd_pkg::in_t               req,
	input  logic                       done,
	input  psd_pkg::out_t              rsp,
	input  logic                       cfg_we,
	input  logic [psd_pkg::VCNT_W-1:0] cfg_wdata,
	output int                         fail_count,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [15:0]         poly_x [psd_pkg::MAX_VERTICES];
	logic signed [15:0]         poly_y [psd_pkg::MAX_VERTICES];
	logic [psd_pkg::VCNT_W-1:0] corner_reg;
	psd_pkg::out_t              dist_q[$];

	assign pending = dist_q.size();

	function automatic longint round_half_up(longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	function automatic longint int_root(longint d);
		longint r, b;
		r = 0;
		b = 64'sd1 << 62;
		while (b > d) b = b >>> 2;
		while (b != 0) begin
			if (d >= r + b) begin
				d = d - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	// Minimum squared edge distance, parity, rounded root, saturation
	function automatic psd_pkg::out_t signed_dist(longint px, longint py);
		psd_pkg::out_t o;
		int     n, i, j;
		longint ex, ey, wx, wy, num, den, t, bx, by, bb, d, r;
		bit     in_poly, ca, cb, cc;
		n = int'(corner_reg);
		if (n < int'(psd_pkg::VCOUNT_MIN)) n = int'(psd_pkg::VCOUNT_MIN);
		if (n > psd_pkg::MAX_VERTICES) n = psd_pkg::MAX_VERTICES;
		in_poly = 0;
		d = (px - poly_x[0]) * (px - poly_x[0]) + (py - poly_y[0]) * (py - poly_y[0]);
		j = n - 1;
		for (i = 0; i < n; i++) begin
			ex = longint'(poly_x[j]) - poly_x[i];
			ey = longint'(poly_y[j]) - poly_y[i];
			wx = px - poly_x[i];
			wy = py - poly_y[i];
			num = wx * ex + wy * ey;
			den = ex * ex + ey * ey;
			if (num <= 0 || den <= 0) t = 0;
			else if (num >= den) t = 65536;
			else t = (num <<< 16) / den;
			bx = wx - round_half_up(ex * t);
			by = wy - round_half_up(ey * t);
			bb = bx * bx + by * by;
			if (bb < d) d = bb;
			ca = py >= poly_y[i];
			cb = py < poly_y[j];
			cc = ex * wy > ey * wx;
			if (ca == cb && cb == cc) in_poly = !in_poly;
			j = i;
		end
		r = int_root(d);
		if (d - r * r > r) r++;
		o.saturated = 0;
		o.inside_res = in_poly;
		if (in_poly) begin
			if (r > 32768) begin
				r = 32768;
				o.saturated = 1;
			end
			o.signed_distance = 16'(-r);
		end else begin
			if (r > 32767) begin
				r = 32767;
				o.saturated = 1;
			end
			o.signed_distance = 16'(r);
		end
		return o;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_reg <= psd_pkg::VCOUNT_RST;
		end else begin
			psd_pkg::out_t want;
			// Result beat against the oldest expectation
			if (done) begin
				if (dist_q.size() == 0) begin
					report("unexpected beat", rsp.signed_distance, 0);
				end else begin
					want = dist_q.pop_front();
					if (rsp.signed_distance !== want.signed_distance)
						report("signed_distance", rsp.signed_distance, want.signed_distance);
					if (rsp.inside_res !== want.inside_res)
						report("inside_res", rsp.inside_res, want.inside_res);
					if (rsp.saturated !== want.saturated)
						report("saturated", rsp.saturated, want.saturated);
				end
			end
			if (cfg_we) corner_reg <= cfg_wdata;
			// Request beat
			if (start && !busy) begin
				if (req.mode == psd_pkg::MODE_WRITE) begin
					poly_x[req.vertex_index] = req.x_coord;
					poly_y[req.vertex_index] = req.y_coord;
				end else begin
					dist_q.push_back(signed_dist(req.x_coord, req.y_coord));
				end
			end
		end
	end
endmodule

FILE: sim/polygon_signed_distance_tb.sv
// polygon_signed_distance_tb: stimulus and verdict for the polygon signed
// distance block. Depends on psd_pkg, polygon_signed_distance and the checker.
module polygon_signed_distance_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;

	logic                       clk = 0;
	logic                       arst_n = 0;
	logic                       start = 0;
	logic                       busy, done;
	psd_pkg::in_t               req = '0;
	psd_pkg::out_t              rsp;
	logic                       cfg_we = 0;
	logic [psd_pkg::VCNT_W-1:0] cfg_wdata = '0;
	int                         fail_count, pending;
	int                         idle_cycles = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	polygon_signed_distance dut (.*);
	polygon_signed_distance_chk chk (.*);

	// Watchdog on cycles with no beat
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Drive one beat and hold until accepted
	task automatic send(logic m, logic [3:0] idx, logic [15:0] x, logic [15:0] y);
		start <= 1;
		req <= '{mode: m, vertex_index: idx, x_coord: x, y_coord: y};
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic gap();
		if ($urandom_range(0, 3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic drain();
		start <= 0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_count(logic [psd_pkg::VCNT_W-1:0] v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [15:0] rnd_coord(int spread);
		case (spread)
			0: return 16'($urandom_range(0, 8191) - 4096);
			1: return 16'($urandom);
			default: return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
		endcase
	endfunction

	initial begin
		int k, n_items, sp;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// Directed: fill all slots (no unwritten reads), square polygon
		for (k = 0; k < 16; k++)
			send(psd_pkg::MODE_WRITE, 4'(k), 16'(k * 100), 16'(-k * 50));
		send(psd_pkg::MODE_WRITE, 0, 16'sh1000, 16'sh1000);
		send(psd_pkg::MODE_WRITE, 1, -16'sh1000, 16'sh1000);
		send(psd_pkg::MODE_WRITE, 2, -16'sh1000, -16'sh1000);
		send(psd_pkg::MODE_WRITE, 3, 16'sh1000, -16'sh1000);
		set_count(4);
		send(psd_pkg::MODE_QUERY, 4'hF, 0, 0);
		send(psd_pkg::MODE_QUERY, 0, 16'sh7FFF, 16'sh7FFF);
		send(psd_pkg::MODE_QUERY, 0, 16'sh8000, 16'sh8000);
		send(psd_pkg::MODE_QUERY, 0, 16'sh8000, 16'sh7FFF);
		send(psd_pkg::MODE_QUERY, 0, 16'sh1000, 16'sh1000);
		// Zero-length edge: duplicate vertex
		send(psd_pkg::MODE_WRITE, 3, 16'sh1000, 16'sh1000);
		send(psd_pkg::MODE_QUERY, 0, 16'sh0100, -16'sh0200);
		// Huge inside distance: extreme triangle
		send(psd_pkg::MODE_WRITE, 0, 16'sh8000, 16'sh8000);
		send(psd_pkg::MODE_WRITE, 1, 16'sh7FFF, 16'sh8000);
		send(psd_pkg::MODE_WRITE, 2, 16'sh0000, 16'sh7FFF);
		set_count(3);
		send(psd_pkg::MODE_QUERY, 0, 16'sh0000, -16'sh2000);
		send(psd_pkg::MODE_QUERY, 0, 16'sh7FFF, 16'sh7FFF);
		// Out of range counts
		set_count(0);
		send(psd_pkg::MODE_QUERY, 0, 16'sh0010, 16'sh0010);
		set_count(31);
		send(psd_pkg::MODE_QUERY, 0, 16'sh0010, 16'sh0010);
		set_count(16);
		send(psd_pkg::MODE_QUERY, 0, 16'sh0010, 16'sh0010);
		// Random phases: new count, new polygon, queries with bursts
		n_items = 0;
		while (n_items < 1100) begin
			set_count(5'($urandom_range(0, 31)));
			sp = $urandom_range(0, 9) == 0 ? 1 : 0;
			for (k = 0; k < 16; k++) begin
				send(psd_pkg::MODE_WRITE, 4'(k), rnd_coord(sp), rnd_coord(sp));
				gap();
				n_items++;
			end
			repeat ($urandom_range(4, 12)) begin
				k = $urandom_range(0, 19);
				sp = (k < 14) ? 0 : (k < 18 ? 1 : 2);
				if ($urandom_range(0, 7) == 0)
					send(psd_pkg::MODE_WRITE, 4'($urandom), rnd_coord(sp), rnd_coord(sp));
				else
					send(psd_pkg::MODE_QUERY, 4'($urandom), rnd_coord(sp), rnd_coord(sp));
				if ($urandom_range(0, 1)) gap();
				n_items++;
			end
		end
		drain();
		repeat (500) begin
			if (pending == 0) break;
			@(negedge clk);
		end
		if (fail_count == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
